// File: design/spi_master_four_mode_assert.svh
// ----------------------------------------------------------------------------
// SPI master assertion macros
// Shorthand for the clocked implication checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_FOUR_MODE_ASSERT_SVH
`define SPI_MASTER_FOUR_MODE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMFM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("SMFM same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("SMFM next-cycle check failed");

`endif

// File: design/smfm_pkg.sv
// ----------------------------------------------------------------------------
// SPI master package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package smfm_pkg;

  localparam int DATA_BITS      = 8;
  localparam int DELAY_BITS     = 16;
  localparam int BIT_CNT_BITS   = $clog2(DATA_BITS);
  localparam int MODE_BITS      = 2;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = DELAY_BITS;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(4);
  localparam logic [MODE_BITS-1:0]  MODE_RESET  = 2'd0;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_TICKS = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPI_MODE    = 1'd1;

  typedef struct packed {
    logic [DELAY_BITS-1:0] delay_ticks;
    logic [MODE_BITS-1:0]  spi_mode;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/smfm_in_if.sv
// ----------------------------------------------------------------------------
// SPI master tick channel
// Valid/ready channel carrying one tick item: MISO level and offered byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface smfm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           miso_level;
  logic                           tx_valid;
  logic [smfm_pkg::DATA_BITS-1:0] tx_byte;
  logic                           tx_end;

  modport source (output valid, output miso_level, output tx_valid, output tx_byte,
                  output tx_end, input ready);
  modport sink (input valid, input miso_level, input tx_valid, input tx_byte,
                input tx_end, output ready);
endinterface

`default_nettype wire

// File: design/smfm_out_if.sv
// ----------------------------------------------------------------------------
// SPI master result channel
// Valid/ready channel carrying pin levels and byte status for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface smfm_out_if;
  logic                           valid;
  logic                           ready;
  logic                           sclk_level;
  logic                           mosi_level;
  logic                           select_n;
  logic                           tx_taken;
  logic                           rx_valid;
  logic [smfm_pkg::DATA_BITS-1:0] rx_byte;
  logic                           rx_end;
  logic                           busy_res;

  modport source (output valid, output sclk_level, output mosi_level, output select_n,
                  output tx_taken, output rx_valid, output rx_byte, output rx_end,
                  output busy_res, input ready);
  modport sink (input valid, input sclk_level, input mosi_level, input select_n,
                input tx_taken, input rx_valid, input rx_byte, input rx_end,
                input busy_res, output ready);
endinterface

`default_nettype wire

// File: design/smfm_cfg_if.sv
// ----------------------------------------------------------------------------
// SPI master configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface smfm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [smfm_pkg::CFG_INDEX_BITS-1:0] index;
  logic [smfm_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/smfm_cfg_regs.sv
// ----------------------------------------------------------------------------
// SPI master configuration registers
// Holds the delay length and the SPI mode; writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module smfm_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  smfm_cfg_if.sink         cfg_ch,
  output smfm_pkg::cfg_t   cfg
);

  smfm_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ticks <= smfm_pkg::DELAY_RESET;
      cfg_r.spi_mode    <= smfm_pkg::MODE_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        smfm_pkg::REG_DELAY_TICKS: begin
          cfg_r.delay_ticks <= cfg_ch.data;
        end
        smfm_pkg::REG_SPI_MODE: begin
          cfg_r.spi_mode <= cfg_ch.data[smfm_pkg::MODE_BITS-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/smfm_core.sv
// ----------------------------------------------------------------------------
// SPI master tick engine
// Input register, transfer state machine and result register for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module smfm_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire smfm_pkg::cfg_t  cfg,
  smfm_in_if.sink              in_ch,
  smfm_out_if.source           out_ch
);

  localparam int DB = smfm_pkg::DATA_BITS;
  localparam int TB = smfm_pkg::DELAY_BITS;
  localparam int BB = smfm_pkg::BIT_CNT_BITS;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_Q0, PH_Q1, PH_Q2, PH_Q3, PH_WAIT,
    PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_STOP_D
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [TB-1:0]   tick_r, tick_nxt;
  logic [BB-1:0]   bit_r, bit_nxt;
  logic [DB-1:0]   tx_shift_r, tx_shift_nxt;
  logic [DB-1:0]   rx_shift_r, rx_shift_nxt;
  logic            end_pending_r, end_pending_nxt;
  logic            sclk_r, sclk_nxt;
  logic            mosi_r, mosi_nxt;
  logic            sel_r, sel_nxt;

  logic            in_vld_r;
  logic            miso_r;
  logic            txv_r;
  logic [DB-1:0]   txb_r;
  logic            txe_r;

  logic            out_vld_r;
  logic            o_sclk_r, o_mosi_r, o_sel_r, o_taken_r, o_rxv_r, o_rxe_r, o_busy_r;
  logic [DB-1:0]   o_rxb_r;

  logic            advance, step;
  logic            taken, rxv, rxe;
  logic [DB-1:0]   rxb;
  logic            idle_lvl, samp_lvl;
  logic [TB-1:0]   dlen, tick_inc;
  logic            expired;
  logic [DB-1:0]   rx_in;

  assign advance     = !out_vld_r || out_ch.ready;
  assign step        = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  assign idle_lvl = cfg.spi_mode[1];
  assign samp_lvl = cfg.spi_mode[1] ^ cfg.spi_mode[0] ^ 1'b1;
  assign dlen     = (cfg.delay_ticks == '0) ? TB'(1) : cfg.delay_ticks;
  assign tick_inc = tick_r + TB'(1);
  assign expired  = (tick_inc >= dlen);
  assign rx_in    = {rx_shift_r[DB-2:0], miso_r};

  always_comb begin
    phase_nxt       = phase_r;
    tick_nxt        = tick_r;
    bit_nxt         = bit_r;
    tx_shift_nxt    = tx_shift_r;
    rx_shift_nxt    = rx_shift_r;
    end_pending_nxt = end_pending_r;
    sclk_nxt        = sclk_r;
    mosi_nxt        = mosi_r;
    sel_nxt         = sel_r;
    taken           = 1'b0;
    rxv             = 1'b0;
    rxe             = 1'b0;
    rxb             = '0;

    if (phase_r == PH_IDLE || phase_r == PH_WAIT) begin
      if (phase_r == PH_IDLE) begin
        sclk_nxt = idle_lvl;
      end
      if (txv_r) begin
        tx_shift_nxt    = txb_r;
        rx_shift_nxt    = '0;
        bit_nxt         = '0;
        end_pending_nxt = txe_r;
        tick_nxt        = '0;
        taken           = 1'b1;
        phase_nxt       = (phase_r == PH_IDLE) ? PH_START_A : PH_Q0;
      end
    end else begin
      tick_nxt = expired ? '0 : tick_inc;
      if (expired) begin
        unique case (phase_r)
          PH_START_A: begin
            sel_nxt   = 1'b0;
            phase_nxt = PH_START_B;
          end
          PH_START_B: begin
            phase_nxt = PH_Q0;
          end
          PH_Q0: begin
            sclk_nxt  = ~samp_lvl;
            phase_nxt = PH_Q1;
          end
          PH_Q1: begin
            mosi_nxt     = tx_shift_r[DB-1];
            tx_shift_nxt = {tx_shift_r[DB-2:0], 1'b0};
            phase_nxt    = PH_Q2;
          end
          PH_Q2: begin
            sclk_nxt  = samp_lvl;
            phase_nxt = PH_Q3;
          end
          PH_Q3: begin
            rx_shift_nxt = rx_in;
            if (bit_r == BB'(DB - 1)) begin
              bit_nxt   = '0;
              rxv       = 1'b1;
              rxb       = rx_in;
              rxe       = end_pending_r;
              phase_nxt = end_pending_r ? PH_STOP_A : PH_WAIT;
            end else begin
              bit_nxt   = bit_r + BB'(1);
              phase_nxt = PH_Q0;
            end
          end
          PH_STOP_A: begin
            sclk_nxt  = idle_lvl;
            phase_nxt = PH_STOP_B;
          end
          PH_STOP_B: begin
            mosi_nxt  = 1'b1;
            phase_nxt = PH_STOP_C;
          end
          PH_STOP_C: begin
            sel_nxt   = 1'b1;
            phase_nxt = PH_STOP_D;
          end
          default: begin
            end_pending_nxt = 1'b0;
            phase_nxt       = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      phase_r       <= PH_IDLE;
      tick_r        <= '0;
      bit_r         <= '0;
      tx_shift_r    <= '0;
      rx_shift_r    <= '0;
      end_pending_r <= 1'b0;
      sclk_r        <= smfm_pkg::MODE_RESET[1];
      mosi_r        <= 1'b1;
      sel_r         <= 1'b1;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (step) begin
        phase_r       <= phase_nxt;
        tick_r        <= tick_nxt;
        bit_r         <= bit_nxt;
        tx_shift_r    <= tx_shift_nxt;
        rx_shift_r    <= rx_shift_nxt;
        end_pending_r <= end_pending_nxt;
        sclk_r        <= sclk_nxt;
        mosi_r        <= mosi_nxt;
        sel_r         <= sel_nxt;
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      miso_r <= in_ch.miso_level;
      txv_r  <= in_ch.tx_valid;
      txb_r  <= in_ch.tx_byte;
      txe_r  <= in_ch.tx_end;
    end
    if (step) begin
      o_sclk_r  <= sclk_nxt;
      o_mosi_r  <= mosi_nxt;
      o_sel_r   <= sel_nxt;
      o_taken_r <= taken;
      o_rxv_r   <= rxv;
      o_rxb_r   <= rxb;
      o_rxe_r   <= rxe;
      o_busy_r  <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.sclk_level = o_sclk_r;
  assign out_ch.mosi_level = o_mosi_r;
  assign out_ch.select_n   = o_sel_r;
  assign out_ch.tx_taken   = o_taken_r;
  assign out_ch.rx_valid   = o_rxv_r;
  assign out_ch.rx_byte    = o_rxb_r;
  assign out_ch.rx_end     = o_rxe_r;
  assign out_ch.busy_res   = o_busy_r;

endmodule

`default_nettype wire

// File: design/spi_master_four_mode.sv
// ----------------------------------------------------------------------------
// SPI master, modes 0 to 3
// Tick-stepped SPI master with configurable quarter-bit delay and mode.
// ----------------------------------------------------------------------------
// Each item on in_ch is one tick of time. It carries the sampled MISO level
// and may offer a transmit byte with an end-of-transfer mark. For every
// accepted item exactly one item appears on out_ch with the SCLK, MOSI and
// select levels after that tick, plus byte taken and byte received flags.
// The cfg_ch port writes delay_ticks (index 0) and spi_mode (index 1); it
// is always ready and should only be written while no item is in flight.
// An accepted item is held in the input register and moves into the result
// register once that is free or being taken. One item is accepted every
// cycle while out_ch does not stall, each item stepping the engine one tick.
// When out_ch stalls, the result register holds and the input register
// fills; in_ch.ready then drops until the result is taken.
// Synchronous reset clears both channels, returns the transfer engine to
// idle with select and MOSI high, and restores delay_ticks 4 and mode 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_master_four_mode_assert.svh"

module spi_master_four_mode (
  input  wire logic  clk,
  input  wire logic  rst_n,
  smfm_in_if.sink    in_ch,
  smfm_out_if.source out_ch,
  smfm_cfg_if.sink   cfg_ch
);

  smfm_pkg::cfg_t cfg;

  smfm_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  smfm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  `SMFM_ASSERT_IMPLY(a_rx_zero_when_idle, clk, rst_n,
    out_ch.valid && !out_ch.rx_valid, out_ch.rx_byte == '0 && !out_ch.rx_end)
  `SMFM_ASSERT_IMPLY(a_taken_implies_busy, clk, rst_n,
    out_ch.valid && out_ch.tx_taken, out_ch.busy_res)
  `SMFM_ASSERT_IMPLY(a_select_only_busy, clk, rst_n,
    out_ch.valid && !out_ch.select_n, out_ch.busy_res)
  `SMFM_ASSERT_IMPLY(a_ready_low_only_on_stall, clk, rst_n,
    !in_ch.ready, out_ch.valid && !out_ch.ready)

endmodule

`default_nettype wire
